// File: hw/rtl/pqcm_pkg.sv
// Package: shared types, codes and constants of the portal quad corner matcher.
package pqcm_pkg;

    localparam int COORD_W = 24;
    localparam int OPND_W  = 27;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int ACC_W   = 56;
    localparam int SQ_IN_W  = 48;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int LSUM_W  = SQ_OUT_W + 1;
    localparam int TOL_W   = 26;
    localparam int SURF_W  = 15;

    localparam logic [2:0] MODE_ENT_C  = 3'd0;
    localparam logic [2:0] MODE_ENT_F  = 3'd1;
    localparam logic [2:0] MODE_ENT_S  = 3'd2;
    localparam logic [2:0] MODE_SEAM_C = 3'd3;
    localparam logic [2:0] MODE_SEAM_F = 3'd4;
    localparam logic [2:0] MODE_SEAM_S = 3'd5;

    localparam logic [1:0] STATUS_NONE   = 2'd0;
    localparam logic [1:0] STATUS_UNIQUE = 2'd1;
    localparam logic [1:0] STATUS_AMBIG  = 2'd2;

    localparam logic [1:0] CFG_POS_TERM = 2'd0;
    localparam logic [1:0] CFG_ROT_GAIN = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_SQRT,
        S_GAIN,
        S_TOL,
        S_PAIR_SEL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [15:0]        world_id;
        logic               crosses;
        logic signed [15:0] surface;
        logic               last_seam;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SURF_W-1:0] match_surface;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic [SQ_IN_W-1:0] value;
    } sq_req_t;

    typedef struct packed {
        logic                done;
        logic [SQ_OUT_W-1:0] root;
    } sq_rsp_t;

endpackage

// File: hw/rtl/pqcm_mul.sv
// Shared signed multiplier with registered product.
module pqcm_mul (
    input  logic                                 clk,
    input  logic signed [pqcm_pkg::OPND_W-1:0]   opa,
    input  logic signed [pqcm_pkg::OPND_W-1:0]   opb,
    output logic signed [pqcm_pkg::PROD_W-1:0]   prod
);
    import pqcm_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
    end

    assign prod = prod_reg;

endmodule

// File: hw/rtl/pqcm_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module pqcm_isqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  pqcm_pkg::sq_req_t req,
    output pqcm_pkg::sq_rsp_t rsp
);
    import pqcm_pkg::*;

    localparam int CNT_W = $clog2(SQ_OUT_W);

    logic [SQ_IN_W-1:0] n_reg, n_next;
    logic [SQ_IN_W-1:0] root_reg, root_next;
    logic [SQ_IN_W-1:0] bit_reg, bit_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [SQ_IN_W:0]   trial;

    always_comb
    begin
        n_next    = n_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, root_reg} + {1'b0, bit_reg};
        if (req.start)
        begin
            n_next    = req.value;
            root_next = '0;
            bit_next  = SQ_IN_W'(1) << (SQ_IN_W - 2);
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, n_reg} >= trial)
            begin
                n_next    = n_reg - trial[SQ_IN_W-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SQ_OUT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg[SQ_OUT_W-1:0];

endmodule

// File: hw/rtl/portal_quad_corner_matcher.sv
// Top level: portal quad corner matcher, sequencer around shared multiplier and root unit.
// Modes 0, 1, 3, 4 and unused modes are taken in S_IDLE without leaving it, so in_stall stays low.
// Mode 2 (entrance second axis) runs two 24-step square roots, then the gain and tolerance steps.
// Mode 5 (seam second axis) compares up to ten corner pairs against the squared tolerance.
// A finished result waits in the output register; a further last seam waits until it drains.
// Reset is asynchronous; control state and stored vectors clear at once, no clearing pass.
module portal_quad_corner_matcher (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pqcm_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pqcm_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [23:0]          cfg_data
);
    import pqcm_pkg::*;

    state_t                    state_reg, state_next;
    logic [2:0]                ph_reg, ph_next;
    logic                      lv_reg, lv_next;
    logic                      lenm_reg, lenm_next;
    logic [1:0]                a_reg, a_next;
    logic [1:0]                b_reg, b_next;
    logic [3:0]                claimed_reg, claimed_next;
    logic                      hit_reg, hit_next;
    logic                      match_reg, match_next;
    logic                      amb_reg, amb_next;
    logic [SURF_W-1:0]         held_reg, held_next;
    logic [23:0]               pos_reg, pos_next;
    logic [15:0]               gain_reg, gain_next;
    logic signed [COORD_W-1:0] ent_reg [9];
    logic signed [COORD_W-1:0] ent_next [9];
    logic signed [COORD_W-1:0] seam_reg [9];
    logic signed [COORD_W-1:0] seam_next [9];
    logic [15:0]               ent_world_reg, ent_world_next;
    logic [ACC_W-1:0]          tol2_reg, tol2_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_data_reg, out_data_next;

    logic signed [OPND_W-1:0]  opa_reg, opa_next;
    logic signed [OPND_W-1:0]  opb_reg, opb_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [LSUM_W-1:0]         lsum_reg, lsum_next;
    logic [TOL_W-1:0]          tol_reg, tol_next;
    logic [SURF_W-1:0]         surf_reg, surf_next;
    logic                      last_reg, last_next;

    logic signed [PROD_W-1:0]  prod;
    sq_req_t                   sq_req;
    sq_rsp_t                   sq_rsp;

    logic [1:0]                comp;
    logic signed [OPND_W-1:0]  e_val, c_val, diff, len_op;

    pqcm_mul u_mul (
        .clk  (clk),
        .opa  (opa_reg),
        .opb  (opb_reg),
        .prod (prod)
    );

    pqcm_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    // corner difference component for the current pair
    always_comb
    begin
        comp = (ph_reg < 3'd3) ? ph_reg[1:0] : 2'd0;
        e_val = OPND_W'(ent_reg[4'(comp)]);
        e_val = a_reg[1] ? e_val - OPND_W'(ent_reg[4'(comp) + 4'd3])
                         : e_val + OPND_W'(ent_reg[4'(comp) + 4'd3]);
        e_val = a_reg[0] ? e_val - OPND_W'(ent_reg[4'(comp) + 4'd6])
                         : e_val + OPND_W'(ent_reg[4'(comp) + 4'd6]);
        c_val = OPND_W'(seam_reg[4'(comp)]);
        c_val = b_reg[1] ? c_val - OPND_W'(seam_reg[4'(comp) + 4'd3])
                         : c_val + OPND_W'(seam_reg[4'(comp) + 4'd3]);
        c_val = b_reg[0] ? c_val - OPND_W'(seam_reg[4'(comp) + 4'd6])
                         : c_val + OPND_W'(seam_reg[4'(comp) + 4'd6]);
        diff   = e_val - c_val;
        len_op = OPND_W'(ent_reg[4'(comp) + (lv_reg ? 4'd6 : 4'd3)]);
    end

    always_comb
    begin
        logic             m;
        logic             am;
        logic [SURF_W-1:0] h;
        logic [3:0]       base;

        state_next     = state_reg;
        ph_next        = ph_reg;
        lv_next        = lv_reg;
        lenm_next      = lenm_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        claimed_next   = claimed_reg;
        hit_next       = hit_reg;
        match_next     = match_reg;
        amb_next       = amb_reg;
        held_next      = held_reg;
        pos_next       = pos_reg;
        gain_next      = gain_reg;
        ent_next       = ent_reg;
        seam_next      = seam_reg;
        ent_world_next = ent_world_reg;
        tol2_next      = tol2_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        acc_next       = acc_reg;
        lsum_next      = lsum_reg;
        tol_next       = tol_reg;
        surf_next      = surf_reg;
        last_next      = last_reg;
        sq_req.start   = 1'b0;
        sq_req.value   = acc_reg[SQ_IN_W-1:0];
        m              = match_reg;
        am             = amb_reg;
        h              = held_reg;
        base           = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            if (cfg_index == CFG_POS_TERM)
            begin
                pos_next = cfg_data;
            end
            else if (cfg_index == CFG_ROT_GAIN)
            begin
                gain_next = cfg_data[15:0];
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.mode <= MODE_ENT_S)
                    begin
                        base = 4'(in_data.mode) * 4'd3;
                        ent_next[base]        = in_data.x;
                        ent_next[base + 4'd1] = in_data.y;
                        ent_next[base + 4'd2] = in_data.z;
                        if (in_data.mode == MODE_ENT_S)
                        begin
                            ent_world_next = in_data.world_id;
                            lv_next        = 1'b0;
                            lenm_next      = 1'b1;
                            lsum_next      = '0;
                            ph_next        = '0;
                            state_next     = S_DIST;
                        end
                    end
                    else if (in_data.mode == MODE_SEAM_C || in_data.mode == MODE_SEAM_F)
                    begin
                        base = (in_data.mode == MODE_SEAM_C) ? 4'd0 : 4'd3;
                        seam_next[base]        = in_data.x;
                        seam_next[base + 4'd1] = in_data.y;
                        seam_next[base + 4'd2] = in_data.z;
                    end
                    else if (in_data.mode == MODE_SEAM_S)
                    begin
                        seam_next[6] = in_data.x;
                        seam_next[7] = in_data.y;
                        seam_next[8] = in_data.z;
                        surf_next    = in_data.surface[SURF_W-1:0];
                        last_next    = in_data.last_seam;
                        a_next       = '0;
                        b_next       = '0;
                        claimed_next = '0;
                        hit_next     = 1'b0;
                        lenm_next    = 1'b0;
                        if (in_data.crosses && !in_data.surface[15]
                            && in_data.world_id == ent_world_reg)
                        begin
                            state_next = S_PAIR_SEL;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                end
            end

            S_DIST:
            begin
                ph_next = ph_reg + 3'd1;
                if (ph_reg < 3'd3)
                begin
                    opa_next = lenm_reg ? len_op : diff;
                    opb_next = lenm_reg ? len_op : diff;
                end
                if (ph_reg == 3'd0)
                begin
                    acc_next = '0;
                end
                else if (ph_reg >= 3'd2 && ph_reg <= 3'd4)
                begin
                    acc_next = acc_reg + {2'b00, prod};
                end
                if (ph_reg == 3'd5)
                begin
                    if (lenm_reg)
                    begin
                        sq_req.start = 1'b1;
                        state_next   = S_SQRT;
                    end
                    else if (acc_reg <= tol2_reg)
                    begin
                        claimed_next[b_reg] = 1'b1;
                        if (a_reg == 2'd3)
                        begin
                            hit_next   = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            a_next     = a_reg + 2'd1;
                            b_next     = '0;
                            state_next = S_PAIR_SEL;
                        end
                    end
                    else if (b_reg == 2'd3)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        b_next     = b_reg + 2'd1;
                        state_next = S_PAIR_SEL;
                    end
                end
            end

            S_SQRT:
            begin
                if (sq_rsp.done)
                begin
                    lsum_next = lsum_reg + {1'b0, sq_rsp.root};
                    ph_next   = '0;
                    if (!lv_reg)
                    begin
                        lv_next    = 1'b1;
                        state_next = S_DIST;
                    end
                    else
                    begin
                        state_next = S_GAIN;
                    end
                end
            end

            S_GAIN:
            begin
                ph_next  = ph_reg + 3'd1;
                opa_next = OPND_W'({11'b0, gain_reg});
                opb_next = OPND_W'({2'b00, lsum_reg});
                if (ph_reg == 3'd2)
                begin
                    tol_next   = {2'b00, pos_reg} + prod[41:16];
                    ph_next    = '0;
                    state_next = S_TOL;
                end
            end

            S_TOL:
            begin
                ph_next  = ph_reg + 3'd1;
                opa_next = OPND_W'({1'b0, tol_reg});
                opb_next = OPND_W'({1'b0, tol_reg});
                if (ph_reg == 3'd2)
                begin
                    tol2_next  = {2'b00, prod};
                    state_next = S_IDLE;
                end
            end

            S_PAIR_SEL:
            begin
                if (claimed_reg[b_reg])
                begin
                    if (b_reg == 2'd3)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        b_next = b_reg + 2'd1;
                    end
                end
                else
                begin
                    ph_next    = '0;
                    state_next = S_DIST;
                end
            end

            S_FINISH:
            begin
                if (hit_reg)
                begin
                    if (match_reg)
                    begin
                        am = 1'b1;
                    end
                    else
                    begin
                        m = 1'b1;
                        h = surf_reg;
                    end
                end
                if (!last_reg)
                begin
                    match_next = m;
                    amb_next   = am;
                    held_next  = h;
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (am)
                    begin
                        out_data_next.status        = STATUS_AMBIG;
                        out_data_next.match_surface = '0;
                    end
                    else if (m)
                    begin
                        out_data_next.status        = STATUS_UNIQUE;
                        out_data_next.match_surface = h;
                    end
                    else
                    begin
                        out_data_next.status        = STATUS_NONE;
                        out_data_next.match_surface = '0;
                    end
                    match_next = 1'b0;
                    amb_next   = 1'b0;
                    held_next  = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= '0;
            lv_reg        <= 1'b0;
            lenm_reg      <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            claimed_reg   <= '0;
            hit_reg       <= 1'b0;
            match_reg     <= 1'b0;
            amb_reg       <= 1'b0;
            held_reg      <= '0;
            pos_reg       <= '0;
            gain_reg      <= '0;
            ent_reg       <= '{default: '0};
            seam_reg      <= '{default: '0};
            ent_world_reg <= '0;
            tol2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            lv_reg        <= lv_next;
            lenm_reg      <= lenm_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            claimed_reg   <= claimed_next;
            hit_reg       <= hit_next;
            match_reg     <= match_next;
            amb_reg       <= amb_next;
            held_reg      <= held_next;
            pos_reg       <= pos_next;
            gain_reg      <= gain_next;
            ent_reg       <= ent_next;
            seam_reg      <= seam_next;
            ent_world_reg <= ent_world_next;
            tol2_reg      <= tol2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        acc_reg      <= acc_next;
        lsum_reg     <= lsum_next;
        tol_reg      <= tol_next;
        surf_reg     <= surf_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n) amb_reg |-> match_reg)
        else $error("ambiguous flag set without a prior match");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAIR_SEL) |-> ($countones(claimed_reg) == int'(a_reg)))
        else $error("claimed corner count out of step with entrance corner");

    assert property (@(posedge clk) disable iff (!rst_n) sq_rsp.done |-> (state_reg == S_SQRT))
        else $error("square root finished outside its wait state");

endmodule
